// File: rtl/core/rsi_pkg.sv
// Shared widths, constants and codes of the ray-sphere intersection block.
package rsi_pkg;

    // Field widths.
    localparam int POS_W  = 32;
    localparam int DIR_W  = 16;
    localparam int DIA_W  = 31;
    localparam int DIST_W = 32;
    localparam int HIT_W  = 2;

    // Fractional bits of the direction.
    localparam int DIR_FRAC = 14;

    // Internal widths, sized to the value bounds of the fields.
    localparam int OC_W   = POS_W + 1;           // origin minus centre
    localparam int PROD_W = OC_W + DIR_W;        // one term of the dot product
    localparam int BSUM_W = PROD_W + 2;          // the dot product before scaling
    localparam int B_W    = 36;                  // scaled dot product
    localparam int SQ_W   = 2 * OC_W;            // one squared component
    localparam int Q_W    = SQ_W + 2;            // sum of squared components
    localparam int BB_W   = 2 * B_W;             // b squared
    localparam int DD_W   = 2 * DIA_W;           // diameter squared
    localparam int RAD_W  = 72;                  // four times the discriminant
    localparam int DISC_W = RAD_W + 1;           // signed difference
    localparam int ROOT_W = RAD_W / 2;           // square root
    localparam int REM_W  = ROOT_W + 2;          // remainder of the root
    localparam int ROOTS_W = ROOT_W + 2;         // doubled roots

    // Hit counts.
    localparam logic [HIT_W-1:0] HIT_MISS    = 2'd0;
    localparam logic [HIT_W-1:0] HIT_TANGENT = 2'd1;
    localparam logic [HIT_W-1:0] HIT_CROSS   = 2'd2;

endpackage

// File: rtl/core/rsi_if.sv
// Request and result channels of the ray-sphere intersection block.
interface rsi_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rsi_pkg::POS_W-1:0]     origin_x;
    logic signed [rsi_pkg::POS_W-1:0]     origin_y;
    logic signed [rsi_pkg::POS_W-1:0]     origin_z;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_x;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_y;
    logic signed [rsi_pkg::DIR_W-1:0]     dir_z;
    logic signed [rsi_pkg::POS_W-1:0]     center_x;
    logic signed [rsi_pkg::POS_W-1:0]     center_y;
    logic signed [rsi_pkg::POS_W-1:0]     center_z;
    logic        [rsi_pkg::DIA_W-1:0]     diameter;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    center_x, center_y, center_z, diameter, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    center_x, center_y, center_z, diameter, output ready);
endinterface

interface rsi_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [rsi_pkg::HIT_W-1:0]     hit_count;
    logic signed [rsi_pkg::DIST_W-1:0]    distance;

    modport source (output valid, hit_count, distance, input ready);
    modport sink   (input valid, hit_count, distance, output ready);
endinterface

// File: rtl/core/ray_sphere_intersect.sv
// Top level of the pipelined fixed-point ray-sphere intersection block.
// One ray-sphere test enters per cycle while the skid register is empty;
// six arithmetic stages form the discriminant, thirty-six stages take its
// square root one result bit each, and two stages choose and saturate the
// root. A two-place output (last stage plus a skid register) lets the block
// take one more request while a result waits; once the skid register holds
// a result the whole pipeline holds until it is taken.
module ray_sphere_intersect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsi_req_if.sink           i_req,
    rsi_rsp_if.source         o_rsp
);

    localparam int SQ_N = rsi_pkg::ROOT_W;

    logic w_en;

    // Stage 1: origin minus centre.
    logic                                  r_v1;
    logic signed [rsi_pkg::OC_W-1:0]       r_oc1 [3];
    logic signed [rsi_pkg::DIR_W-1:0]      r_d1  [3];
    logic        [rsi_pkg::DIA_W-1:0]      r_dia1;

    // Stage 2: dot product terms and squared components.
    logic                                  r_v2;
    logic signed [rsi_pkg::PROD_W-1:0]     r_pr2 [3];
    logic signed [rsi_pkg::SQ_W-1:0]       r_sq2 [3];
    logic        [rsi_pkg::DIA_W-1:0]      r_dia2;

    // Stage 3: b and the squared length.
    logic                                  r_v3;
    logic signed [rsi_pkg::B_W-1:0]        r_b3;
    logic signed [rsi_pkg::Q_W-1:0]        r_q3;
    logic        [rsi_pkg::DIA_W-1:0]      r_dia3;

    // Stage 4: squares of b and of the diameter.
    logic                                  r_v4;
    logic signed [rsi_pkg::B_W-1:0]        r_b4;
    logic signed [rsi_pkg::BB_W-1:0]       r_bb4;
    logic        [rsi_pkg::DD_W-1:0]       r_dd4;
    logic signed [rsi_pkg::Q_W-1:0]        r_q4;

    // Stage 5: the two sides of four times the discriminant.
    logic                                  r_v5;
    logic signed [rsi_pkg::B_W-1:0]        r_b5;
    logic        [rsi_pkg::RAD_W-1:0]      r_p5;
    logic        [rsi_pkg::RAD_W-1:0]      r_q5;

    // Square root pipeline; entry zero is the discriminant stage.
    logic                                  r_sq_v    [SQ_N+1];
    logic        [rsi_pkg::RAD_W-1:0]      r_sq_rad  [SQ_N+1];
    logic        [rsi_pkg::REM_W-1:0]      r_sq_rem  [SQ_N+1];
    logic        [rsi_pkg::ROOT_W-1:0]     r_sq_root [SQ_N+1];
    logic signed [rsi_pkg::B_W-1:0]        r_sq_b    [SQ_N+1];
    logic        [rsi_pkg::HIT_W-1:0]      r_sq_hit  [SQ_N+1];

    // Root stage and final stage.
    logic                                  r_vr;
    logic signed [rsi_pkg::ROOTS_W-1:0]    r_n2;
    logic signed [rsi_pkg::ROOTS_W-1:0]    r_f2;
    logic        [rsi_pkg::HIT_W-1:0]      r_hit_r;
    logic                                  r_fin_v;
    logic        [rsi_pkg::HIT_W-1:0]      r_fin_hit;
    logic signed [rsi_pkg::DIST_W-1:0]     r_fin_dist;

    // Skid register.
    logic                                  r_skid_v;
    logic        [rsi_pkg::HIT_W-1:0]      r_skid_hit;
    logic signed [rsi_pkg::DIST_W-1:0]     r_skid_dist;

    logic signed [rsi_pkg::BSUM_W-1:0]     w_bsum;
    logic signed [rsi_pkg::DISC_W-1:0]     w_disc;
    logic signed [rsi_pkg::ROOTS_W-1:0]    w_twob;
    logic signed [rsi_pkg::ROOTS_W-1:0]    w_sel;
    logic signed [rsi_pkg::ROOTS_W-2:0]    w_half;

    // The pipeline moves whenever the skid register is empty.
    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_req.valid;
        end
        if (w_en) begin
            r_oc1[0] <= {i_req.origin_x[rsi_pkg::POS_W-1], i_req.origin_x}
                      - {i_req.center_x[rsi_pkg::POS_W-1], i_req.center_x};
            r_oc1[1] <= {i_req.origin_y[rsi_pkg::POS_W-1], i_req.origin_y}
                      - {i_req.center_y[rsi_pkg::POS_W-1], i_req.center_y};
            r_oc1[2] <= {i_req.origin_z[rsi_pkg::POS_W-1], i_req.origin_z}
                      - {i_req.center_z[rsi_pkg::POS_W-1], i_req.center_z};
            r_d1[0]  <= i_req.dir_x;
            r_d1[1]  <= i_req.dir_y;
            r_d1[2]  <= i_req.dir_z;
            r_dia1   <= i_req.diameter;
        end
    end

    // Stage 2: one multiplier per product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pr2[k] <= r_d1[k] * r_oc1[k];
                r_sq2[k] <= r_oc1[k] * r_oc1[k];
            end
            r_dia2 <= r_dia1;
        end
    end

    // Stage 3: sums; the arithmetic shift floors b.
    assign w_bsum = rsi_pkg::BSUM_W'(r_pr2[0]) + rsi_pkg::BSUM_W'(r_pr2[1])
                  + rsi_pkg::BSUM_W'(r_pr2[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
        if (w_en) begin
            r_b3   <= w_bsum[rsi_pkg::DIR_FRAC +: rsi_pkg::B_W];
            r_q3   <= rsi_pkg::Q_W'(r_sq2[0]) + rsi_pkg::Q_W'(r_sq2[1])
                    + rsi_pkg::Q_W'(r_sq2[2]);
            r_dia3 <= r_dia2;
        end
    end

    // Stage 4: squares of b and the diameter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
        if (w_en) begin
            r_b4  <= r_b3;
            r_bb4 <= r_b3 * r_b3;
            r_dd4 <= r_dia3 * r_dia3;
            r_q4  <= r_q3;
        end
    end

    // Stage 5: 4*b*b + d*d and 4*|oc|^2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
        if (w_en) begin
            r_b5 <= r_b4;
            r_p5 <= {r_bb4[rsi_pkg::RAD_W-3:0], 2'b00}
                  + rsi_pkg::RAD_W'(r_dd4);
            r_q5 <= {2'b00, r_q4[rsi_pkg::RAD_W-5:0], 2'b00};
        end
    end

    // Stage 6: discriminant sign and the radicand for the root.
    assign w_disc = $signed({1'b0, r_p5}) - $signed({1'b0, r_q5});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_v5;
        end
        if (w_en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_b[0]    <= r_b5;
            if (w_disc[rsi_pkg::DISC_W-1]) begin
                r_sq_rad[0] <= '0;
                r_sq_hit[0] <= rsi_pkg::HIT_MISS;
            end else begin
                r_sq_rad[0] <= w_disc[rsi_pkg::RAD_W-1:0];
                r_sq_hit[0] <= (w_disc == '0) ? rsi_pkg::HIT_TANGENT : rsi_pkg::HIT_CROSS;
            end
        end
    end

    // Square root stages: one result bit per stage, restoring method.
    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        logic [rsi_pkg::REM_W+1:0] w_t;
        logic [rsi_pkg::REM_W+1:0] w_trial;

        assign w_t     = {r_sq_rem[g], r_sq_rad[g][rsi_pkg::RAD_W-1 -: 2]};
        assign w_trial = {2'b00, r_sq_root[g], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[g+1] <= r_sq_v[g];
            end
            if (w_en) begin
                r_sq_rad[g+1] <= {r_sq_rad[g][rsi_pkg::RAD_W-3:0], 2'b00};
                r_sq_b[g+1]   <= r_sq_b[g];
                r_sq_hit[g+1] <= r_sq_hit[g];
                if (w_t >= w_trial) begin
                    r_sq_rem[g+1]  <= rsi_pkg::REM_W'(w_t - w_trial);
                    r_sq_root[g+1] <= {r_sq_root[g][rsi_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_sq_rem[g+1]  <= w_t[rsi_pkg::REM_W-1:0];
                    r_sq_root[g+1] <= {r_sq_root[g][rsi_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Root stage: the doubled near and far roots.
    assign w_twob = {{(rsi_pkg::ROOTS_W-rsi_pkg::B_W-1){r_sq_b[SQ_N][rsi_pkg::B_W-1]}},
                     r_sq_b[SQ_N], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else if (w_en) begin
            r_vr <= r_sq_v[SQ_N];
        end
        if (w_en) begin
            r_n2    <= -w_twob - $signed({2'b00, r_sq_root[SQ_N]});
            r_f2    <= -w_twob + $signed({2'b00, r_sq_root[SQ_N]});
            r_hit_r <= r_sq_hit[SQ_N];
        end
    end

    // Final stage: pick the root, halve with floor, saturate; a miss gives zero.
    assign w_sel  = (r_n2 > 0) ? r_n2 : r_f2;
    assign w_half = w_sel[rsi_pkg::ROOTS_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= r_vr;
        end
        if (w_en) begin
            r_fin_hit <= r_hit_r;
            if (r_hit_r == rsi_pkg::HIT_MISS) begin
                r_fin_dist <= '0;
            end else if (w_half > $signed({1'b0, {(rsi_pkg::DIST_W-1){1'b1}}})) begin
                r_fin_dist <= {1'b0, {(rsi_pkg::DIST_W-1){1'b1}}};
            end else if (w_half < $signed({1'b1, {(rsi_pkg::DIST_W-1){1'b0}}})) begin
                r_fin_dist <= {1'b1, {(rsi_pkg::DIST_W-1){1'b0}}};
            end else begin
                r_fin_dist <= w_half[rsi_pkg::DIST_W-1:0];
            end
        end
    end

    // Skid register catches the last stage when the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_rsp.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_fin_v && !o_rsp.ready) begin
            r_skid_v <= 1'b1;
        end
        if (!r_skid_v) begin
            r_skid_hit  <= r_fin_hit;
            r_skid_dist <= r_fin_dist;
        end
    end

    assign o_rsp.valid     = r_skid_v || r_fin_v;
    assign o_rsp.hit_count = r_skid_v ? r_skid_hit : r_fin_hit;
    assign o_rsp.distance  = r_skid_v ? r_skid_dist : r_fin_dist;

`ifndef SYNTHESIS
    // A miss always reports zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit_count == rsi_pkg::HIT_MISS) |-> o_rsp.distance == '0)
        else $error("miss with nonzero distance");

    // No hit code beyond two crossings.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.hit_count == rsi_pkg::HIT_MISS
                         || o_rsp.hit_count == rsi_pkg::HIT_TANGENT
                         || o_rsp.hit_count == rsi_pkg::HIT_CROSS))
        else $error("bad hit count");

    // While the skid register is held, the last stage keeps its result.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_rsp.ready) |=> ($stable(r_fin_v) && $stable(r_fin_dist)))
        else $error("last stage changed during stall");

    // The skid register only fills behind a valid last stage.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_fin_v))
        else $error("skid filled without a result");
`endif

endmodule
